[rtl/tcq_pkg.sv]
// ----------------------------------------------------------------------------
// tcq_pkg
// Shared types and constants for the two-class minimum-ticket queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcq_pkg;

    // Number of cells in the sorted chain
    localparam int DEPTH       = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int TICKET_W    = 16;
    localparam int STATUS_W    = 3;
    localparam int ENTRIES_W   = 5;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // Contents of one cell; the sort key is {cls, ticket}
    typedef struct packed {
        logic                valid;
        logic                cls;
        logic [TICKET_W-1:0] ticket;
    } entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic                push;
        logic                pop;
        logic                cls;
        logic [TICKET_W-1:0] ticket;
    } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/tcq_cell.sv]
// ----------------------------------------------------------------------------
// tcq_cell
// One cell of the sorted chain. Holds one entry; on a push it keeps its entry,
// takes the new one or takes its lower neighbour's; on a pop it takes its
// upper neighbour's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tcq_cell
    import tcq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire entry_t    prev_entry,   // lower neighbour
    input  wire logic      prev_lt,      // lower neighbour sorts below new key
    input  wire entry_t    next_entry,   // upper neighbour
    output entry_t         entry,
    output logic           lt,           // this entry sorts below new key
    output logic           hit           // this entry holds the pushed ticket
);

    logic                valid_reg;
    logic                valid_next;
    logic                cls_reg;
    logic                cls_next;
    logic [TICKET_W-1:0] ticket_reg;
    logic [TICKET_W-1:0] ticket_next;

    assign entry = '{valid: valid_reg, cls: cls_reg, ticket: ticket_reg};

    // Compare against the incoming key
    assign lt  = valid_reg && ({cls_reg, ticket_reg} < {cmd.cls, cmd.ticket});
    assign hit = valid_reg && (ticket_reg == cmd.ticket);

    // Next contents
    always_comb
    begin
        valid_next  = valid_reg;
        cls_next    = cls_reg;
        ticket_next = ticket_reg;
        if (cmd.pop)
        begin
            valid_next  = next_entry.valid;
            cls_next    = next_entry.cls;
            ticket_next = next_entry.ticket;
        end
        else if (cmd.push && !lt)
        begin
            if (prev_lt)
            begin
                valid_next  = 1'b1;
                cls_next    = cmd.cls;
                ticket_next = cmd.ticket;
            end
            else
            begin
                valid_next  = prev_entry.valid;
                cls_next    = prev_entry.cls;
                ticket_next = prev_entry.ticket;
            end
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cls_reg    <= cls_next;
        ticket_reg <= ticket_next;
    end

endmodule

`default_nettype wire

[rtl/two_class_min_ticket_queue_top.sv]
// ----------------------------------------------------------------------------
// two_class_min_ticket_queue_top
// Two-class priority queue of tickets held sorted in a chain of cells.
// ----------------------------------------------------------------------------
// A word is registered on acceptance and its result is registered when the
// word executes, which waits while an offered result has not been taken.
// A new word is not accepted while the input register still holds one, so
// words pass through the queue one at a time.
// Reset: rst_n clears all cell valid flags, the count and the handshakes.
`default_nettype none

module two_class_min_ticket_queue_top
    import tcq_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // op, entry_class, ticket[15:0], pad
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // status[2:0], served_class,
                                                    // served_ticket[15:0],
                                                    // entries_left[4:0], pad
);

    logic                in_valid_reg;
    logic                in_valid_next;
    logic                op_reg;
    logic                cls_reg;
    logic [TICKET_W-1:0] ticket_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    logic                sclass_reg;
    logic [TICKET_W-1:0] sticket_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                exec;
    logic                dup;
    status_t             status;
    cell_cmd_t           cmd;
    entry_t              cell_q  [DEPTH];
    logic [DEPTH-1:0]    cell_lt;
    logic [DEPTH-1:0]    cell_hit;

    // Handshake
    assign s_tready = !in_valid_reg;
    assign exec     = in_valid_reg && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (exec)
            in_valid_next = 1'b0;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (exec)
            out_valid_next = 1'b1;
    end

    // Decode the operation against the chain
    assign dup = |cell_hit;

    always_comb
    begin
        status = ST_OK;
        if (op_reg == OP_PUSH)
        begin
            if (ticket_reg == '0)
                status = ST_INVALID;
            else if (dup)
                status = ST_DUPLICATE;
            else if (count_reg == CNT_W'(DEPTH))
                status = ST_FULL;
        end
        else if (!cell_q[0].valid)
        begin
            status = ST_EMPTY;
        end
    end

    assign cmd = '{push:   exec && (op_reg == OP_PUSH) && (status == ST_OK),
                   pop:    exec && (op_reg == OP_POP) && (status == ST_OK),
                   cls:    cls_reg,
                   ticket: ticket_reg};

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.pop)
            count_next = count_reg - CNT_W'(1);
    end

    // Sorted chain: cell 0 holds the next entry to serve
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            entry_t prev_e;
            entry_t next_e;
            logic   prev_l;
            if (gi == 0)
            begin : g_first
                assign prev_e = '0;
                assign prev_l = 1'b1;
            end
            else
            begin : g_mid
                assign prev_e = cell_q[gi-1];
                assign prev_l = cell_lt[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign next_e = '0;
            end
            else
            begin : g_upper
                assign next_e = cell_q[gi+1];
            end
            tcq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_entry (prev_e),
                .prev_lt    (prev_l),
                .next_entry (next_e),
                .entry      (cell_q[gi]),
                .lt         (cell_lt[gi]),
                .hit        (cell_hit[gi])
            );
        end
    endgenerate

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // Input word register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg     <= s_tdata[0];
            cls_reg    <= s_tdata[1];
            ticket_reg <= s_tdata[TICKET_W+1:2];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            status_reg  <= status;
            sclass_reg  <= cmd.pop ? cell_q[0].cls : 1'b0;
            sticket_reg <= cmd.pop ? cell_q[0].ticket : '0;
        end
    end

    assign m_tdata = {{(OUT_TDATA_W - STATUS_W - 1 - TICKET_W - ENTRIES_W){1'b0}},
                      ENTRIES_W'(count_reg), sticket_reg, sclass_reg, status_reg};

endmodule

`default_nettype wire
